/* rtl/idle_sleep_window_ramp_core_defines.svh */
// Assertion macros shared by the idle sleep window ramp RTL.
`ifndef IDLE_SLEEP_WINDOW_RAMP_CORE_DEFINES_SVH
`define IDLE_SLEEP_WINDOW_RAMP_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ISWR_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("iswr assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ISWR_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("iswr assertion failed");

`endif

/* rtl/iswr_pkg.sv */
// Package with the types and constants of the idle sleep window ramp core.
package iswr_pkg;

    // Width of the free-running millisecond clock that produces the timestamps.
    localparam int TIME_WIDTH = 32;
    localparam int MASK_BITS  = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;
    localparam logic [31:0] IDLE_MASK = 32'hFFFF_FFFF >> (32 - MASK_BITS);

    // One restoring division step per stage, one stage per quotient bit.
    localparam int DIV_STAGES = 32;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_SCHED_ENABLE   = 3'd0,
        REG_IDLE_THRESHOLD = 3'd1,
        REG_MIN_WINDOW     = 3'd2,
        REG_MAX_WINDOW     = 3'd3,
        REG_RAMP_INTERVAL  = 3'd4
    } cfg_reg_t;

    // How the window of a word is finally chosen.
    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_CEIL = 2'd1,
        KIND_RAMP = 2'd2
    } kind_t;

endpackage

/* rtl/idle_sleep_window_ramp_core.sv */
// Top level of the idle sleep window ramp core: a pipelined sleep window calculator.
//
// Usage: each input word on the slave stream carries the current millisecond time
// (s_tdata[31:0]) and the time of last activity (s_tdata[63:32]). For each word the
// core returns exactly one output word on the master stream, the sleep window in ms
// (m_tdata[31:0]); a value of 0 means the system should stay awake.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the
// five settings; cfg_ready is always high and unknown indexes are dropped. The user
// must change settings only while no word is in flight; the core does not enforce it.
// The pipeline has 36 register stages: one stage forms the idle time, one classifies it,
// 32 stages each produce one quotient bit of the division by the ramp interval, one
// stage shifts the start window, and the output register clamps it. A new word can
// enter every cycle while the receiver does not stall, so sustained throughput is one
// word per cycle.
// When the receiver stalls with a word waiting in the output register, the whole
// pipeline freezes and s_tready drops; nothing is lost or repeated.
// Reset clears all settings to zero and empties the pipeline.
`include "idle_sleep_window_ramp_core_defines.svh"

module idle_sleep_window_ramp_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // now_ms [31:0], last_busy_ms [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // sleep_ms [31:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int LAST = iswr_pkg::DIV_STAGES - 1;

    // Configuration registers.
    logic        sched_enable_reg;
    logic [31:0] idle_threshold_reg;
    logic [31:0] min_window_reg;
    logic [31:0] max_window_reg;
    logic [31:0] ramp_interval_reg;

    // The whole pipeline moves together; it holds only while the output word waits.
    logic advance;

    // Stage A: idle time.
    logic        a_valid_reg;
    logic [31:0] a_idle_reg;

    // Stage B: classification and numerator of the division.
    logic                b_valid_reg;
    iswr_pkg::kind_t     b_kind_reg;
    iswr_pkg::kind_t     b_kind_next;
    logic [31:0]         b_num_reg;

    // Divider stages: partial remainder and the shift register that turns from
    // dividend into quotient one bit per stage.
    logic [iswr_pkg::DIV_STAGES-1:0] dv_valid_reg;
    iswr_pkg::kind_t dv_kind_reg [iswr_pkg::DIV_STAGES];
    logic [31:0]     dv_rem_reg  [iswr_pkg::DIV_STAGES];
    logic [31:0]     dv_nq_reg   [iswr_pkg::DIV_STAGES];
    logic [31:0]     dv_rem_next [iswr_pkg::DIV_STAGES];
    logic [31:0]     dv_nq_next  [iswr_pkg::DIV_STAGES];
    logic [32:0]     dv_trial    [iswr_pkg::DIV_STAGES];
    logic [32:0]     dv_diff     [iswr_pkg::DIV_STAGES];
    logic [iswr_pkg::DIV_STAGES-1:0] dv_ge;
    logic            dv_last_ramp;

    // Stage X: start window shifted by the number of doublings.
    logic            x_valid_reg;
    iswr_pkg::kind_t x_kind_reg;
    logic            x_big_reg;
    logic [63:0]     x_prod_reg;
    logic [31:0]     start_window;

    // Output register.
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic [31:0] out_data_next;
    logic [31:0] ceil_ms;
    logic [31:0] ramp_window;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_enable_reg   <= 1'b0;
            idle_threshold_reg <= '0;
            min_window_reg     <= '0;
            max_window_reg     <= '0;
            ramp_interval_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                iswr_pkg::REG_SCHED_ENABLE:   sched_enable_reg   <= cfg_data[0];
                iswr_pkg::REG_IDLE_THRESHOLD: idle_threshold_reg <= cfg_data;
                iswr_pkg::REG_MIN_WINDOW:     min_window_reg     <= cfg_data;
                iswr_pkg::REG_MAX_WINDOW:     max_window_reg     <= cfg_data;
                iswr_pkg::REG_RAMP_INTERVAL:  ramp_interval_reg  <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Stage B decision: disabled or not yet idle long enough gives a zero window,
    // a zero ramp interval goes straight to the ceiling, anything else ramps.
    always_comb
    begin
        if (!sched_enable_reg || (a_idle_reg < idle_threshold_reg))
            b_kind_next = iswr_pkg::KIND_ZERO;
        else if (ramp_interval_reg == '0)
            b_kind_next = iswr_pkg::KIND_CEIL;
        else
            b_kind_next = iswr_pkg::KIND_RAMP;
    end

    // One restoring division step per stage. For ramping words the remainder stays below
    // the ramp interval, so it fits 32 bits after each step.
    always_comb
    begin
        dv_trial[0]    = {1'b0, 31'd0, b_num_reg[31]};
        dv_diff[0]     = dv_trial[0] - {1'b0, ramp_interval_reg};
        dv_ge[0]       = (dv_trial[0] >= {1'b0, ramp_interval_reg});
        dv_rem_next[0] = dv_ge[0] ? dv_diff[0][31:0] : dv_trial[0][31:0];
        dv_nq_next[0]  = {b_num_reg[30:0], dv_ge[0]};
        for (int j = 1; j < iswr_pkg::DIV_STAGES; j++)
        begin
            dv_trial[j]    = {dv_rem_reg[j-1], dv_nq_reg[j-1][31]};
            dv_diff[j]     = dv_trial[j] - {1'b0, ramp_interval_reg};
            dv_ge[j]       = (dv_trial[j] >= {1'b0, ramp_interval_reg});
            dv_rem_next[j] = dv_ge[j] ? dv_diff[j][31:0] : dv_trial[j][31:0];
            dv_nq_next[j]  = {dv_nq_reg[j-1][30:0], dv_ge[j]};
        end
    end

    // A zero minimum starts the ramp at one millisecond.
    assign start_window = (min_window_reg != '0) ? min_window_reg : 32'd1;

    // The ceiling is the larger of max and min. Doubling the start window q times
    // and stopping at the ceiling is the same as min(start << q, ceiling); any
    // quotient of 32 or more always reaches the ceiling.
    assign ceil_ms     = (max_window_reg < min_window_reg) ? min_window_reg : max_window_reg;
    assign ramp_window = (x_big_reg || (x_prod_reg > {32'd0, ceil_ms})) ?
                         ceil_ms : x_prod_reg[31:0];

    always_comb
    begin
        case (x_kind_reg)
            iswr_pkg::KIND_ZERO: out_data_next = '0;
            iswr_pkg::KIND_CEIL: out_data_next = ceil_ms;
            iswr_pkg::KIND_RAMP:
            begin
                out_data_next = (ramp_window < min_window_reg) ? min_window_reg : ramp_window;
            end
            default:             out_data_next = '0;
        endcase
    end

    // Valid bits of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            dv_valid_reg  <= '0;
            x_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg   <= s_tvalid;
            b_valid_reg   <= a_valid_reg;
            dv_valid_reg  <= {dv_valid_reg[iswr_pkg::DIV_STAGES-2:0], b_valid_reg};
            x_valid_reg   <= dv_valid_reg[LAST];
            out_valid_reg <= x_valid_reg;
        end
    end

    // Payload of every stage.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_idle_reg     <= (s_tdata[31:0] - s_tdata[63:32]) & iswr_pkg::IDLE_MASK;
            b_kind_reg     <= b_kind_next;
            b_num_reg      <= a_idle_reg - idle_threshold_reg;
            dv_kind_reg[0] <= b_kind_reg;
            for (int j = 1; j < iswr_pkg::DIV_STAGES; j++)
            begin
                dv_kind_reg[j] <= dv_kind_reg[j-1];
            end
            for (int j = 0; j < iswr_pkg::DIV_STAGES; j++)
            begin
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_nq_reg[j]  <= dv_nq_next[j];
            end
            x_kind_reg   <= dv_kind_reg[LAST];
            x_big_reg    <= |dv_nq_reg[LAST][31:5];
            x_prod_reg   <= {32'd0, start_window} << dv_nq_reg[LAST][4:0];
            out_data_reg <= out_data_next;
        end
    end

    assign dv_last_ramp = dv_valid_reg[LAST] && (dv_kind_reg[LAST] == iswr_pkg::KIND_RAMP);

    // The window never exceeds the ceiling.
    `ISWR_ASSERT_NOW(a_out_below_ceil, m_tvalid, m_tdata <= ceil_ms)
    // A nonzero window never falls below the minimum.
    `ISWR_ASSERT_NOW(a_out_above_min, m_tvalid, (m_tdata == '0) || (m_tdata >= min_window_reg))
    // The last divider remainder stays below the ramp interval for ramping words.
    `ISWR_ASSERT_NOW(a_rem_below_ramp, dv_last_ramp, dv_rem_reg[LAST] < ramp_interval_reg)

endmodule
